/* rtl/core/umpr_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the usb midi packet router
package umpr_pkg;

   localparam int SYSEX_CAPACITY = 128;
   localparam int RESULT_MAX     = 6;
   localparam int RES_IDX_W      = $clog2(RESULT_MAX + 1);

   // result kinds
   localparam logic [2:0] KIND_SYSEX_BYTE = 3'd0;
   localparam logic [2:0] KIND_SYSEX_DONE = 3'd1;
   localparam logic [2:0] KIND_PROGRAM    = 3'd2;
   localparam logic [2:0] KIND_NOTE_LED   = 3'd3;
   localparam logic [2:0] KIND_THRU       = 3'd4;

   // code index numbers
   localparam logic [3:0] CIN_TWO_BYTE_COMMON = 4'h2;
   localparam logic [3:0] CIN_SYSEX_CONT      = 4'h4;
   localparam logic [3:0] CIN_SYSEX_END1      = 4'h5;
   localparam logic [3:0] CIN_SYSEX_END2      = 4'h6;
   localparam logic [3:0] CIN_SYSEX_END3      = 4'h7;
   localparam logic [3:0] CIN_PROGRAM         = 4'hC;
   localparam logic [3:0] CIN_PRESSURE        = 4'hD;
   localparam logic [3:0] CIN_SINGLE_BYTE     = 4'hF;

   localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;

   // status high nibbles
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
   localparam logic [3:0] STATUS_PROGRAM  = 4'hC;

   typedef struct packed {
      logic [7:0] third_byte;
      logic [7:0] second_byte;
      logic [7:0] first_byte;
      logic [7:0] header;
   } packet_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [7:0] velocity;
      logic [7:0] position;
   } res_entry_type;

   typedef struct packed {
      logic [RES_IDX_W-1:0]                count;
      res_entry_type [RESULT_MAX-1:0]      entry;
   } res_list_type;

endpackage

/* rtl/core/umpr_decode.sv */
`timescale 1ns / 1ps
// packet decode: builds the result list and next sysex state for one packet
module umpr_decode
   import umpr_pkg::*;
(
   input  packet_type   pkt,
   input  logic         in_sysex,
   input  logic [7:0]   sysex_count,
   input  logic         thru_enable,
   output res_list_type list,
   output logic         next_in_sysex,
   output logic [7:0]   next_sysex_count
);

   logic [3:0]             cin;
   logic                   is_sysex;
   logic [2:0][7:0]        pkt_bytes;
   logic [3:0]             s_chain;
   logic [3:0][7:0]        c_chain;
   res_entry_type [RESULT_MAX-1:0] cand;
   logic [RESULT_MAX-1:0]  cand_en;
   logic [1:0]             thru_len;
   logic                   chan_one;

   assign cin       = pkt.header[3:0];
   assign pkt_bytes = {pkt.third_byte, pkt.second_byte, pkt.first_byte};
   assign chan_one  = (pkt.first_byte[3:0] == 4'h0);

   assign is_sysex = (cin == CIN_SYSEX_CONT) || (pkt.first_byte == BYTE_SYSEX_START) ||
                     (in_sysex && ((cin == CIN_SYSEX_END1) || (cin == CIN_SYSEX_END2) ||
                                   (cin == CIN_SYSEX_END3)));

   always_comb begin
      unique case (cin)
         CIN_SYSEX_END1, CIN_SINGLE_BYTE: thru_len = 2'd1;
         CIN_TWO_BYTE_COMMON, CIN_SYSEX_END2, CIN_PROGRAM, CIN_PRESSURE: thru_len = 2'd2;
         default: thru_len = 2'd3;
      endcase
   end

   // sysex chain over the three bytes, one short step each
   always_comb begin
      logic       start_b;
      logic       active_b;
      logic [7:0] c0;
      logic       store_b;
      logic [7:0] c1;
      s_chain[0] = in_sysex;
      c_chain[0] = sysex_count;
      cand       = '0;
      cand_en    = '0;
      for (int i = 0; i < 3; i++) begin
         start_b  = (pkt_bytes[i] == BYTE_SYSEX_START);
         active_b = s_chain[i] || start_b;
         c0       = start_b ? 8'd0 : c_chain[i];
         store_b  = active_b && (c0 < 8'(SYSEX_CAPACITY));
         c1       = store_b ? (c0 + 8'd1) : c0;
         cand[2*i].kind       = KIND_SYSEX_BYTE;
         cand[2*i].value      = pkt_bytes[i];
         cand[2*i].velocity   = 8'd0;
         cand[2*i].position   = c0;
         cand[2*i+1].kind     = KIND_SYSEX_DONE;
         cand[2*i+1].value    = 8'd0;
         cand[2*i+1].velocity = 8'd0;
         cand[2*i+1].position = c1;
         cand_en[2*i]         = store_b;
         cand_en[2*i+1]       = active_b && (pkt_bytes[i] == BYTE_SYSEX_END);
         s_chain[i+1] = active_b ? (pkt_bytes[i] != BYTE_SYSEX_END) : s_chain[i];
         c_chain[i+1] = active_b ? c1 : c_chain[i];
      end

      if (!is_sysex) begin
         cand    = '0;
         cand_en = '0;
         cand[0].value = pkt.second_byte;
         unique case (pkt.first_byte[7:4])
            STATUS_PROGRAM: begin
               cand[0].kind = KIND_PROGRAM;
               cand_en[0]   = chan_one;
            end
            STATUS_NOTE_ON: begin
               cand[0].kind     = KIND_NOTE_LED;
               cand[0].velocity = pkt.third_byte;
               cand_en[0]       = chan_one;
            end
            STATUS_NOTE_OFF: begin
               cand[0].kind = KIND_NOTE_LED;
               cand_en[0]   = chan_one;
            end
            default: begin
               cand[0].kind = KIND_PROGRAM;
            end
         endcase
         for (int j = 0; j < 3; j++) begin
            cand[j+1].kind  = KIND_THRU;
            cand[j+1].value = pkt_bytes[j];
            cand_en[j+1]    = thru_enable && (2'(j) < thru_len);
         end
      end

      if (pkt.header == 8'd0) begin
         cand_en = '0;
      end
   end

   // pack the enabled candidates in order
   always_comb begin
      logic [RES_IDX_W-1:0] n;
      n    = '0;
      list = '0;
      for (int k = 0; k < RESULT_MAX; k++) begin
         if (cand_en[k]) begin
            list.entry[n] = cand[k];
            n = n + 1'b1;
         end
      end
      list.count = n;
   end

   assign next_in_sysex    = (is_sysex && (pkt.header != 8'd0)) ? s_chain[3] : in_sysex;
   assign next_sysex_count = (is_sysex && (pkt.header != 8'd0)) ? c_chain[3] : sysex_count;

endmodule

/* rtl/core/umpr_drain.sv */
`timescale 1ns / 1ps
// result buffer: holds one packet's result list and hands it out one beat a cycle while rsp_tready is high
module umpr_drain
   import umpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  res_list_type list,
   output logic         free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // value, velocity, position
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast
);

   logic [RES_IDX_W-1:0]           count_ff, count_in;
   logic [RES_IDX_W-1:0]           rd_ff, rd_in;
   res_entry_type [RESULT_MAX-1:0] entry_ff;
   res_entry_type                  cur;
   logic                           take;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = (rd_ff == (count_ff - 1'b1));
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = !rsp_tvalid || (take && rsp_tlast);
   assign cur        = entry_ff[rd_ff];
   assign rsp_tdata  = {cur.position, cur.velocity, cur.value};
   assign rsp_tuser  = cur.kind;

   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      if (load) begin
         count_in = list.count;
         rd_in    = '0;
      end else if (take) begin
         if (rsp_tlast) begin
            count_in = '0;
            rd_in    = '0;
         end else begin
            rd_in = rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= list.entry;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RES_IDX_W'(RESULT_MAX))
      else $error("result count above list size");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (rd_ff < count_ff))
      else $error("read index past end of list");
   assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("list loaded over undelivered results");
`endif

endmodule

/* rtl/core/usb_midi_packet_router.sv */
`timescale 1ns / 1ps
// usb midi event packet router top level: input stage, sysex state, decode and result buffer
//
//  port group   dir  payload
//  req_         in   tdata: header, first_byte, second_byte, third_byte
//  rsp_         out  tdata: value, velocity, position; tuser: kind; tlast: last
//  csr_         in   wr_data: thru_enable
//
//  a packet is held in the input register, is decoded in one pass and
//  loaded into the result buffer, which gives 0 to 6 beats, one a cycle
//  while rsp_tready is high;
//  stalls on rsp_ back up through the buffer into the input register
//  synchronous active-high reset clears sysex state, thru enable and valids
module usb_midi_packet_router
   import umpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // header, first_byte, second_byte, third_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // value, velocity, position
   output logic [2:0]  rsp_tuser,    // kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   packet_type   pkt_ff;
   logic         pkt_valid_ff, pkt_valid_in;
   logic         in_sysex_ff, in_sysex_in;
   logic [7:0]   sysex_count_ff, sysex_count_in;
   logic         thru_enable_ff, thru_enable_in;
   logic         req_fire;
   logic         load;
   logic         buf_free;
   res_list_type list;
   logic         next_in_sysex;
   logic [7:0]   next_sysex_count;

   assign load       = pkt_valid_ff && buf_free;
   assign req_tready = !pkt_valid_ff || buf_free;
   assign req_fire   = req_tvalid && req_tready;

   umpr_decode u_decode (
      .pkt              (pkt_ff),
      .in_sysex         (in_sysex_ff),
      .sysex_count      (sysex_count_ff),
      .thru_enable      (thru_enable_ff),
      .list             (list),
      .next_in_sysex    (next_in_sysex),
      .next_sysex_count (next_sysex_count)
   );

   umpr_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .list       (list),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      pkt_valid_in   = pkt_valid_ff;
      in_sysex_in    = in_sysex_ff;
      sysex_count_in = sysex_count_ff;
      thru_enable_in = csr_wr_en ? csr_wr_data : thru_enable_ff;
      if (load) begin
         pkt_valid_in   = 1'b0;
         in_sysex_in    = next_in_sysex;
         sysex_count_in = next_sysex_count;
      end
      if (req_fire) begin
         pkt_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_valid_ff   <= 1'b0;
         in_sysex_ff    <= 1'b0;
         sysex_count_ff <= 8'd0;
         thru_enable_ff <= 1'b0;
      end else begin
         pkt_valid_ff   <= pkt_valid_in;
         in_sysex_ff    <= in_sysex_in;
         sysex_count_ff <= sysex_count_in;
         thru_enable_ff <= thru_enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pkt_ff <= req_tdata;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      sysex_count_ff <= 8'(SYSEX_CAPACITY))
      else $error("sysex count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      (pkt_valid_ff && !buf_free) |=> (pkt_valid_ff && $stable(pkt_ff)))
      else $error("held packet lost or changed");
   assert property (@(posedge clock) disable iff (reset)
      (!load) |=> ($stable(in_sysex_ff) && $stable(sysex_count_ff)))
      else $error("sysex state changed without a packet");
`endif

endmodule

/* sim/usb_midi_packet_router_check.sv */
`timescale 1ns / 1ps
// checker for the usb midi packet router: routes each accepted packet and compares the rsp beats
module usb_midi_packet_router_check
   import umpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // header, first_byte, second_byte, third_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // value, velocity, position
   input  logic [2:0]  rsp_tuser,    // kind
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          mismatches,
   output int          pending
);

   localparam logic [3:0] CHANNEL_1 = 4'h0;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [7:0] velocity;
      logic [7:0] position;
      logic       last;
   } router_beat_type;

   router_beat_type routed_beats[$];
   router_beat_type packet_beats [0:RESULT_MAX-1];
   int              packet_beat_count;
   int              bad_beats = 0;

   // own copy of the router state and thru setting
   logic       thru_on   = 1'b0;
   logic       in_sysex  = 1'b0;
   logic [7:0] sysex_len = 8'd0;

   task automatic add_beat(input logic [2:0] kind, input logic [7:0] value,
                           input logic [7:0] velocity, input logic [7:0] position);
      packet_beats[packet_beat_count] = {kind, value, velocity, position, 1'b0};
      packet_beat_count++;
   endtask

   task automatic take_sysex_byte(input logic [7:0] b);
      // stray bytes outside a message are dropped
      if (in_sysex || b == BYTE_SYSEX_START) begin
         if (b == BYTE_SYSEX_START) begin
            in_sysex  = 1'b1;
            sysex_len = 8'd0;
         end
         if (sysex_len < SYSEX_CAPACITY) begin
            add_beat(KIND_SYSEX_BYTE, b, 8'd0, sysex_len);
            sysex_len = sysex_len + 8'd1;
         end
         // end byte completes even when the buffer is full
         if (b == BYTE_SYSEX_END) begin
            in_sysex = 1'b0;
            add_beat(KIND_SYSEX_DONE, 8'd0, 8'd0, sysex_len);
         end
      end
   endtask

   task automatic route_packet(input packet_type p);
      logic [3:0]      cin;
      logic            is_sysex;
      int              thru_len;
      router_beat_type beat;
      cin = p.header[3:0];
      packet_beat_count = 0;
      if (p.header != 8'd0) begin
         is_sysex = cin == CIN_SYSEX_CONT || p.first_byte == BYTE_SYSEX_START ||
                    (in_sysex && cin >= CIN_SYSEX_END1 && cin <= CIN_SYSEX_END3);
         if (is_sysex) begin
            take_sysex_byte(p.first_byte);
            take_sysex_byte(p.second_byte);
            take_sysex_byte(p.third_byte);
         end else begin
            if (p.first_byte[3:0] == CHANNEL_1) begin
               case (p.first_byte[7:4])
                  STATUS_PROGRAM: begin
                     add_beat(KIND_PROGRAM, p.second_byte, 8'd0, 8'd0);
                  end
                  STATUS_NOTE_ON: begin
                     add_beat(KIND_NOTE_LED, p.second_byte, p.third_byte, 8'd0);
                  end
                  STATUS_NOTE_OFF: begin
                     add_beat(KIND_NOTE_LED, p.second_byte, 8'd0, 8'd0);
                  end
                  default: begin
                  end
               endcase
            end
            if (thru_on) begin
               thru_len = 3;
               if (cin == CIN_SYSEX_END1 || cin == CIN_SINGLE_BYTE)
                  thru_len = 1;
               else if (cin == CIN_TWO_BYTE_COMMON || cin == CIN_SYSEX_END2 ||
                        cin == CIN_PROGRAM || cin == CIN_PRESSURE)
                  thru_len = 2;
               add_beat(KIND_THRU, p.first_byte, 8'd0, 8'd0);
               if (thru_len >= 2)
                  add_beat(KIND_THRU, p.second_byte, 8'd0, 8'd0);
               if (thru_len >= 3)
                  add_beat(KIND_THRU, p.third_byte, 8'd0, 8'd0);
            end
         end
      end
      for (int i = 0; i < packet_beat_count; i++) begin
         beat = packet_beats[i];
         beat.last = (i == packet_beat_count - 1);
         routed_beats.push_back(beat);
      end
   endtask

   task automatic report(input string what, input bit have_want,
                         input router_beat_type want, input router_beat_type got);
      bad_beats++;
      if (bad_beats <= 10) begin
         $display("%0t %s: got kind %0d value %h velocity %h position %0d last %0b",
                  $realtime, what, got.kind, got.value, got.velocity, got.position,
                  got.last);
         if (have_want)
            $display("   expected kind %0d value %h velocity %h position %0d last %0b",
                     want.kind, want.value, want.velocity, want.position, want.last);
      end
   endtask

   always @(posedge clock) begin : watch
      router_beat_type want;
      router_beat_type got;
      if (reset) begin
         thru_on   = 1'b0;
         in_sysex  = 1'b0;
         sysex_len = 8'd0;
         routed_beats.delete();
      end else begin
         if (csr_wr_en)
            thru_on = csr_wr_data;
         if (req_tvalid && req_tready)
            route_packet(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast};
            if (routed_beats.size() == 0) begin
               report("unexpected beat", 1'b0, got, got);
            end else begin
               want = routed_beats.pop_front();
               if (got != want)
                  report("beat mismatch", 1'b1, want, got);
            end
         end
      end
      pending    <= routed_beats.size();
      mismatches <= bad_beats;
   end

endmodule

/* sim/usb_midi_packet_router_test.sv */
`timescale 1ns / 1ps
// testbench top for the usb midi packet router: clock, reset, packet stimulus and verdict
module usb_midi_packet_router_test
   import umpr_pkg::*;
();

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE      = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = 32'd0;    // header, first_byte, second_byte, third_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;              // value, velocity, position
   logic [2:0]  rsp_tuser;              // kind
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   int mismatches;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int packets_sent  = 0;
   int cycle_count   = 0;
   int packets_seen  = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   usb_midi_packet_router dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   usb_midi_packet_router_check checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off once enough packets went in
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            packets_seen++;
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!hold_done && packets_seen >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            hold_left  = HOLD_CYCLES;
            hold_done  = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send(input logic [7:0] header, input logic [7:0] b1,
                       input logic [7:0] b2, input logic [7:0] b3);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b3, b2, b1, header};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      packets_sent++;
   endtask

   // wait until every routed beat came out, then let ignored packets settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_thru(input logic enable);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= enable;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // start packet, body_packets continuation packets, then an end packet of random shape or none
   task automatic send_sysex(input int body_packets);
      logic [3:0] cable;
      int         end_shape;
      cable = 4'($urandom_range(15));
      send({cable, CIN_SYSEX_CONT}, BYTE_SYSEX_START, 8'($urandom_range(127)),
           8'($urandom_range(127)));
      repeat (body_packets)
         send({cable, CIN_SYSEX_CONT}, 8'($urandom_range(127)), 8'($urandom_range(127)),
              8'($urandom_range(127)));
      end_shape = $urandom_range(9);
      // some messages are left open on purpose
      case (end_shape)
         0: begin
         end
         1, 2, 3: begin
            send({cable, CIN_SYSEX_END1}, BYTE_SYSEX_END, 8'h00, 8'h00);
         end
         4, 5, 6: begin
            send({cable, CIN_SYSEX_END2}, 8'($urandom_range(127)), BYTE_SYSEX_END, 8'h00);
         end
         default: begin
            send({cable, CIN_SYSEX_END3}, 8'($urandom_range(127)), 8'($urandom_range(127)),
                 BYTE_SYSEX_END);
         end
      endcase
   endtask

   task automatic run_random(input int count);
      int         first;
      int         pick;
      logic [3:0] status;
      logic [3:0] chan;
      logic [3:0] cin;
      logic [7:0] header;
      first = packets_sent;
      while (packets_sent - first < count) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_sysex($urandom_range(6));
         end else if (pick < 75) begin
            case ($urandom_range(9))
               0, 1, 2: status = STATUS_NOTE_ON;
               3, 4:    status = STATUS_NOTE_OFF;
               5, 6:    status = STATUS_PROGRAM;
               default: status = 4'($urandom_range(8, 15));
            endcase
            chan = ($urandom_range(3) != 0) ? 4'h0 : 4'($urandom_range(15));
            cin  = ($urandom_range(4) != 0) ? status : 4'($urandom_range(15));
            send({4'($urandom_range(15)), cin}, {status, chan}, 8'($urandom_range(255)),
                 8'($urandom_range(255)));
         end else begin
            header = 8'($urandom_range(255));
            if ($urandom_range(4) == 0)
               header = 8'h00;
            send(header, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 28;
      recv_idle_pct <= 70;
      write_thru(1'b0);

      // channel decode, thru off
      send(8'h00, BYTE_SYSEX_START, 8'h01, 8'h02);
      send(8'h09, 8'h90, 8'h00, 8'h7F);
      send(8'h08, 8'h80, 8'h7F, 8'h40);
      send(8'h0C, 8'hC0, 8'h7F, 8'h00);
      send(8'h09, 8'h9F, 8'h3C, 8'h64);
      send(8'h0B, 8'hB0, 8'h07, 8'h7F);
      // sysex: stray bytes, start, continuation, each end shape, restart mid packet
      send(8'h04, 8'h11, 8'h22, 8'h33);
      send(8'h04, BYTE_SYSEX_START, 8'h7E, 8'h7F);
      send(8'h14, 8'h01, 8'h02, 8'h03);
      send(8'h06, 8'h04, BYTE_SYSEX_END, 8'h00);
      send(8'h09, BYTE_SYSEX_START, 8'h01, BYTE_SYSEX_END);
      send(8'h24, BYTE_SYSEX_START, 8'h05, 8'h06);
      send(8'h05, BYTE_SYSEX_END, 8'h00, 8'h00);
      send(8'hF4, BYTE_SYSEX_START, 8'h01, 8'h02);
      send(8'h07, BYTE_SYSEX_END, BYTE_SYSEX_START, BYTE_SYSEX_END);
      send(8'h04, BYTE_SYSEX_START, 8'h01, 8'h02);
      send(8'h34, 8'h03, BYTE_SYSEX_START, 8'h04);
      send(8'h07, 8'h05, 8'h06, BYTE_SYSEX_END);
      send(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drain();

      // thru on: every thru length
      write_thru(1'b1);
      send(8'h05, 8'h90, 8'h01, 8'h02);
      send(8'h02, 8'hC0, 8'h10, 8'h20);
      send(8'h09, 8'h90, 8'h3C, 8'h64);
      send(8'h0D, 8'hD0, 8'h11, 8'h22);
      send(8'h0F, 8'hF8, 8'h00, 8'h00);
      send(8'h06, 8'h80, 8'h01, 8'h02);
      send(8'h0C, 8'hC1, 8'h05, 8'h00);
      send(8'h00, 8'h90, 8'h01, 8'h02);

      // long message that runs past the buffer
      send_sysex(45);
      run_random(130);
      drain();

      write_thru(1'b0);
      send_idle_pct <= 70;
      recv_idle_pct <= 28;
      run_random(150);
      drain();

      write_thru(1'b1);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      run_random(75);
      drain();
      run_random(75);
      drain();

      if (mismatches == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
